[rtl/core/nrmc_pkg.sv]
package nrmc_pkg;

   localparam int SENTENCE_BYTES = 128;
   localparam int HEADER_LEN     = 6;
   localparam int FILL_W         = $clog2(SENTENCE_BYTES + 1);
   localparam int POS_W          = 7;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_P      = 8'h50;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_R      = 8'h52;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_C      = 8'h43;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_LA     = 8'h61;
   localparam logic [7:0] CHAR_LF     = 8'h66;
   localparam logic [7:0] CHAR_UA     = 8'h41;
   localparam logic [7:0] CHAR_UF     = 8'h46;

   typedef struct packed {
      logic [HEADER_LEN-1:0][7:0] window;   // [HEADER_LEN-1] newest
      logic [FILL_W-1:0]          fill_count;
      logic [7:0]                 running_xor;
      logic [7:0]                 recent0;
      logic [7:0]                 recent1;
   } state_type;

   typedef struct packed {
      logic             header_found;
      logic             talker_gn;
      logic             body_byte;
      logic [POS_W-1:0] byte_position;
      logic [7:0]       byte_echo;
      logic             sentence_ok;
      logic [POS_W-1:0] last_index;
      logic             overflow;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      logic [7:0] d;
      h = '0;
      d = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d = c - CHAR_0;
         h.valid = 1'b1;
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         d = c - CHAR_LA + 8'd10;
         h.valid = 1'b1;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d = c - CHAR_UA + 8'd10;
         h.valid = 1'b1;
      end
      h.value = d[3:0];
      return h;
   endfunction

endpackage

[rtl/core/nrmc_if.sv]
interface nrmc_req_if import nrmc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrmc_rsp_if import nrmc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             header_found;
   logic             talker_gn;
   logic             body_byte;
   logic [POS_W-1:0] byte_position;
   logic [7:0]       byte_echo;
   logic             sentence_ok;
   logic [POS_W-1:0] last_index;
   logic             overflow;

   modport source (output valid, output header_found, output talker_gn,
                   output body_byte, output byte_position, output byte_echo,
                   output sentence_ok, output last_index, output overflow,
                   input ready);
   modport sink (input valid, input header_found, input talker_gn,
                 input body_byte, input byte_position, input byte_echo,
                 input sentence_ok, input last_index, input overflow,
                 output ready);
endinterface

[rtl/core/nrmc_step.sv]
module nrmc_step import nrmc_pkg::*; (
   input  state_type  cur_state,
   input  logic [7:0] rx_byte,
   output state_type  nxt_state,
   output result_type result
);

   logic [HEADER_LEN-1:0][7:0] win_shift;
   logic                       is_header;
   hex_type                    h1;
   hex_type                    h2;
   logic [7:0]                 parsed;

   assign win_shift = {rx_byte, cur_state.window[HEADER_LEN-1:1]};

   assign is_header = (win_shift[0] == CHAR_DOLLAR) && (win_shift[1] == CHAR_G) &&
                      ((win_shift[2] == CHAR_P) || (win_shift[2] == CHAR_N)) &&
                      (win_shift[3] == CHAR_R) && (win_shift[4] == CHAR_M) &&
                      (win_shift[5] == CHAR_C);

   assign h1 = hex_decode(cur_state.recent0);
   assign h2 = hex_decode(rx_byte);

   always_comb begin
      if (!h1.valid) begin
         parsed = '0;
      end else if (h2.valid) begin
         parsed = {h1.value, h2.value};
      end else begin
         parsed = {4'd0, h1.value};
      end
   end

   always_comb begin
      nxt_state = cur_state;
      result = '0;
      result.byte_echo = rx_byte;
      if (cur_state.fill_count < FILL_W'(HEADER_LEN)) begin
         nxt_state.window = win_shift;
         if (cur_state.fill_count == FILL_W'(HEADER_LEN - 1)) begin
            if (is_header) begin
               result.header_found = 1'b1;
               result.talker_gn = (win_shift[2] == CHAR_N);
               result.byte_position = POS_W'(HEADER_LEN - 1);
               nxt_state.fill_count = FILL_W'(HEADER_LEN);
               nxt_state.running_xor = win_shift[1] ^ win_shift[2] ^ win_shift[3];
               nxt_state.recent0 = win_shift[5];
               nxt_state.recent1 = win_shift[4];
            end
         end else begin
            nxt_state.fill_count = cur_state.fill_count + 1'b1;
         end
      end else if (cur_state.fill_count >= FILL_W'(SENTENCE_BYTES)) begin
         result.overflow = 1'b1;
         nxt_state = '0;
      end else begin
         result.body_byte = 1'b1;
         result.byte_position = POS_W'(cur_state.fill_count);
         if ((cur_state.recent1 == CHAR_STAR) && (parsed == cur_state.running_xor)) begin
            result.sentence_ok = 1'b1;
            result.last_index = POS_W'(cur_state.fill_count);
            nxt_state = '0;
         end else begin
            nxt_state.running_xor = cur_state.running_xor ^ cur_state.recent1;
            nxt_state.recent1 = cur_state.recent0;
            nxt_state.recent0 = rx_byte;
            nxt_state.fill_count = cur_state.fill_count + 1'b1;
         end
      end
   end

endmodule

[rtl/core/nmea_rmc_sentence_checker_unit.sv]
// Response is registered: each byte passes the input register, then the result register.
// Throughput: one byte per cycle while the response side accepts; sentence state updates in a single step per byte.
// Backpressure on the response side stalls the input register, no byte is lost.
// Reset (synchronous, active high) empties both stages and clears the header window,
// fill count, checksum and recent bytes; the block is ready the cycle after reset.
module nmea_rmc_sentence_checker_unit import nrmc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   nrmc_req_if.sink   req_chan,
   nrmc_rsp_if.source rsp_chan
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   state_type  state_ff;
   state_type  state_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   result_type step_res;
   logic       advance;
   logic       req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   nrmc_step u_step (
      .cur_state (state_ff),
      .rx_byte   (in_byte_ff),
      .nxt_state (state_in),
      .result    (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance) begin
         out_ff <= step_res;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.header_found  = out_ff.header_found;
   assign rsp_chan.talker_gn     = out_ff.talker_gn;
   assign rsp_chan.body_byte     = out_ff.body_byte;
   assign rsp_chan.byte_position = out_ff.byte_position;
   assign rsp_chan.byte_echo     = out_ff.byte_echo;
   assign rsp_chan.sentence_ok   = out_ff.sentence_ok;
   assign rsp_chan.last_index    = out_ff.last_index;
   assign rsp_chan.overflow      = out_ff.overflow;

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      (advance && (step_res.overflow || step_res.sentence_ok)) |=>
      (state_ff.fill_count == '0 && state_ff.running_xor == '0))
      else $error("state not cleared after sentence end");

   a_kind_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0({out_ff.header_found, out_ff.body_byte, out_ff.overflow}))
      else $error("more than one byte kind flagged");

   a_ok_is_body: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.sentence_ok) |-> out_ff.body_byte)
      else $error("sentence end on non-body byte");

   a_gn_needs_header: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.talker_gn) |-> out_ff.header_found)
      else $error("talker flag without header");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.fill_count <= FILL_W'(SENTENCE_BYTES))
      else $error("fill count past limit");

endmodule
